>>> rtl/ede_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package ede_pkg;

    localparam int MAX_LEN  = 32;
    localparam int IDX_W    = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
    localparam int CNT_W    = $clog2(MAX_LEN + 1);
    localparam int DIST_W   = 6;
    localparam int DIST_MAX = (1 << DIST_W) - 1;

    typedef enum logic [1:0] {
        REQ_APPEND_A = 2'd0,
        REQ_APPEND_B = 2'd1,
        REQ_COMPUTE  = 2'd2,
        REQ_UNUSED   = 2'd3
    } t_req_type;

    typedef struct packed {
        logic [1:0] req_type;
        logic [7:0] char_in;
    } t_req;

    typedef struct packed {
        logic [DIST_W-1:0] distance;
        logic              overflow;
    } t_rsp;

    function automatic logic [DIST_W-1:0] sat_dist(input logic [CNT_W-1:0] v);
        if (32'(v) > 32'(DIST_MAX)) begin
            return DIST_W'(DIST_MAX);
        end else begin
            return DIST_W'(v);
        end
    endfunction

endpackage

`default_nettype wire

>>> rtl/ede_cell.sv
`timescale 1ns / 1ps
`default_nettype none

module ede_cell (
    input  wire logic [ede_pkg::CNT_W-1:0] i_up,
    input  wire logic [ede_pkg::CNT_W-1:0] i_left,
    input  wire logic [ede_pkg::CNT_W-1:0] i_diag,
    input  wire logic [7:0]                i_ch_a,
    input  wire logic [7:0]                i_ch_b,
    output logic      [ede_pkg::CNT_W-1:0] o_cell
);
    import ede_pkg::*;

    logic [CNT_W-1:0] min_ul;
    logic [CNT_W-1:0] min_all;

    always_comb begin
        min_ul  = (i_up < i_left) ? i_up : i_left;
        min_all = (i_diag < min_ul) ? i_diag : min_ul;
        if (i_ch_a == i_ch_b) begin
            o_cell = i_diag;
        end else begin
            o_cell = min_all + CNT_W'(1);
        end
    end

endmodule

`default_nettype wire

>>> rtl/edit_distance_engine.sv
`timescale 1ns / 1ps
`default_nettype none

// Levenshtein distance engine. Append beats (type 0 to string A, type 1 to
// string B) are taken one per cycle; characters past MAX_LEN are dropped and
// raise the overflow flag. A compute beat walks the dynamic-programming table
// one cell per cycle, with a fetch step before each row, through a single
// compare/min/increment unit and keeps one row in a small RAM (no walk when
// either string is empty), then offers the result beat. The block is
// not ready during the walk. After the result is registered both strings and
// the flag are cleared. A request type of 3 is accepted and ignored.
module edit_distance_engine (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    output logic               o_in_ready,
    input  wire ede_pkg::t_req i_in_data,
    output logic               o_out_valid,
    input  wire logic          i_out_ready,
    output ede_pkg::t_rsp      o_out_data
);
    import ede_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_FETCH = 4'b0010,
        S_CELL  = 4'b0100,
        S_DONE  = 4'b1000
    } t_state;

    t_state           r_state, n_state;
    logic [CNT_W-1:0] r_count_a, n_count_a;
    logic [CNT_W-1:0] r_count_b, n_count_b;
    logic             r_flag, n_flag;
    logic [CNT_W-1:0] r_i, n_i;
    logic [CNT_W-1:0] r_j, n_j;
    logic [CNT_W-1:0] r_left, n_left;
    logic [CNT_W-1:0] r_diag, n_diag;
    logic [CNT_W-1:0] r_res, n_res;
    logic             r_out_valid, n_out_valid;
    t_rsp             r_out, n_out;

    logic [7:0]       r_str_a [MAX_LEN];
    logic [7:0]       r_str_b [MAX_LEN];
    logic [CNT_W-1:0] r_row   [MAX_LEN];
    logic [7:0]       r_a_rd;
    logic [7:0]       r_b_rd;
    logic [CNT_W-1:0] r_row_rd;

    logic             accept;
    logic             wr_a, wr_b, wr_row;
    logic [IDX_W-1:0] rd_addr;
    logic [IDX_W-1:0] rd_addr_b;
    logic [CNT_W-1:0] i_m1, j_m1;
    logic [CNT_W-1:0] up;
    logic [CNT_W-1:0] dp_val;

    assign o_in_ready  = (r_state == S_IDLE);
    assign accept      = i_in_valid && o_in_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    assign i_m1      = r_i - CNT_W'(1);
    assign j_m1      = r_j - CNT_W'(1);
    assign rd_addr   = (r_state == S_CELL) ? r_i[IDX_W-1:0] : '0;
    assign rd_addr_b = j_m1[IDX_W-1:0];
    assign up        = (r_j == CNT_W'(1)) ? r_i : r_row_rd;

    assign wr_a   = accept && (i_in_data.req_type == REQ_APPEND_A)
                    && (32'(r_count_a) < MAX_LEN);
    assign wr_b   = accept && (i_in_data.req_type == REQ_APPEND_B)
                    && (32'(r_count_b) < MAX_LEN);
    assign wr_row = (r_state == S_CELL);

    ede_cell u_cell (
        .i_up   (up),
        .i_left (r_left),
        .i_diag (r_diag),
        .i_ch_a (r_a_rd),
        .i_ch_b (r_b_rd),
        .o_cell (dp_val)
    );

    always_ff @(posedge i_clk) begin
        if (wr_a) begin
            r_str_a[r_count_a[IDX_W-1:0]] <= i_in_data.char_in;
        end
        r_a_rd <= r_str_a[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (wr_b) begin
            r_str_b[r_count_b[IDX_W-1:0]] <= i_in_data.char_in;
        end
        r_b_rd <= r_str_b[rd_addr_b];
    end

    always_ff @(posedge i_clk) begin
        if (wr_row) begin
            r_row[i_m1[IDX_W-1:0]] <= dp_val;
        end
        r_row_rd <= r_row[rd_addr];
    end

    always_comb begin
        n_state     = r_state;
        n_count_a   = r_count_a;
        n_count_b   = r_count_b;
        n_flag      = r_flag;
        n_i         = r_i;
        n_j         = r_j;
        n_left      = r_left;
        n_diag      = r_diag;
        n_res       = r_res;
        n_out_valid = r_out_valid;
        n_out       = r_out;

        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    case (i_in_data.req_type)
                        REQ_APPEND_A: begin
                            if (wr_a) begin
                                n_count_a = r_count_a + CNT_W'(1);
                            end else begin
                                n_flag = 1'b1;
                            end
                        end
                        REQ_APPEND_B: begin
                            if (wr_b) begin
                                n_count_b = r_count_b + CNT_W'(1);
                            end else begin
                                n_flag = 1'b1;
                            end
                        end
                        REQ_COMPUTE: begin
                            if ((r_count_a == '0) || (r_count_b == '0)) begin
                                n_res   = r_count_a | r_count_b;
                                n_state = S_DONE;
                            end else begin
                                n_j     = CNT_W'(1);
                                n_state = S_FETCH;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_FETCH: begin
                n_i     = CNT_W'(1);
                n_left  = r_j;
                n_diag  = j_m1;
                n_state = S_CELL;
            end
            S_CELL: begin
                n_left = dp_val;
                n_diag = up;
                if (r_i == r_count_a) begin
                    if (r_j == r_count_b) begin
                        n_res   = dp_val;
                        n_state = S_DONE;
                    end else begin
                        n_j     = r_j + CNT_W'(1);
                        n_state = S_FETCH;
                    end
                end else begin
                    n_i = r_i + CNT_W'(1);
                end
            end
            S_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid      = 1'b1;
                    n_out.distance   = sat_dist(r_res);
                    n_out.overflow   = r_flag;
                    n_count_a        = '0;
                    n_count_b        = '0;
                    n_flag           = 1'b0;
                    n_state          = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count_a   <= '0;
            r_count_b   <= '0;
            r_flag      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count_a   <= n_count_a;
            r_count_b   <= n_count_b;
            r_flag      <= n_flag;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_i    <= n_i;
        r_j    <= n_j;
        r_left <= n_left;
        r_diag <= n_diag;
        r_res  <= n_res;
        r_out  <= n_out;
    end

endmodule

`default_nettype wire

>>> bench/edit_distance_engine_test.sv
`timescale 1ns / 1ps

module edit_distance_engine_test;
    import ede_pkg::*;

    localparam int RANDOM_ITEMS = 1300;
    localparam int WATCHDOG     = 8000;
    localparam int SETTLE       = 1200;
    localparam int REPORT_MAX   = 10;

    typedef struct {
        t_req_type         op;
        logic [7:0]        ch;
        int                reps;
        bit                known;
        logic [DIST_W-1:0] want_dist;
        logic              ovf;
    } t_script_row;

    localparam int N_ROWS = 26;

    t_script_row script [N_ROWS] = '{
        '{REQ_COMPUTE,  8'h00, 1,           1'b1, 6'd0,          1'b0},
        '{REQ_UNUSED,   8'hFF, 1,           1'b0, 6'd0,          1'b0},
        '{REQ_APPEND_A, 8'h00, 1,           1'b0, 6'd0,          1'b0},
        '{REQ_APPEND_A, 8'hFF, 1,           1'b0, 6'd0,          1'b0},
        '{REQ_COMPUTE,  8'h00, 1,           1'b1, 6'd2,          1'b0},
        '{REQ_APPEND_B, 8'h55, 3,           1'b0, 6'd0,          1'b0},
        '{REQ_COMPUTE,  8'h00, 1,           1'b1, 6'd3,          1'b0},
        '{REQ_APPEND_A, 8'hAA, 1,           1'b0, 6'd0,          1'b0},
        '{REQ_APPEND_B, 8'hAA, 1,           1'b0, 6'd0,          1'b0},
        '{REQ_COMPUTE,  8'hFF, 1,           1'b1, 6'd0,          1'b0},
        '{REQ_APPEND_A, 8'h00, 1,           1'b0, 6'd0,          1'b0},
        '{REQ_APPEND_B, 8'hFF, 1,           1'b0, 6'd0,          1'b0},
        '{REQ_COMPUTE,  8'h00, 1,           1'b1, 6'd1,          1'b0},
        '{REQ_APPEND_A, 8'hFF, MAX_LEN + 1, 1'b0, 6'd0,          1'b0},
        '{REQ_COMPUTE,  8'h00, 1,           1'b1, 6'(MAX_LEN),   1'b1},
        '{REQ_APPEND_B, 8'h00, MAX_LEN + 8, 1'b0, 6'd0,          1'b0},
        '{REQ_APPEND_A, 8'h00, MAX_LEN,     1'b0, 6'd0,          1'b0},
        '{REQ_UNUSED,   8'h00, 1,           1'b0, 6'd0,          1'b0},
        '{REQ_COMPUTE,  8'h00, 1,           1'b1, 6'd0,          1'b1},
        '{REQ_APPEND_A, 8'h12, MAX_LEN,     1'b0, 6'd0,          1'b0},
        '{REQ_APPEND_B, 8'h34, MAX_LEN,     1'b0, 6'd0,          1'b0},
        '{REQ_COMPUTE,  8'h00, 1,           1'b1, 6'(MAX_LEN),   1'b0},
        '{REQ_APPEND_A, 8'h61, 1,           1'b0, 6'd0,          1'b0},
        '{REQ_APPEND_B, 8'h62, 1,           1'b0, 6'd0,          1'b0},
        '{REQ_APPEND_B, 8'h61, 1,           1'b0, 6'd0,          1'b0},
        '{REQ_COMPUTE,  8'h00, 1,           1'b0, 6'd0,          1'b0}
    };

    logic  i_clk;
    logic  rst_n     = 1'b0;
    logic  in_valid  = 1'b0;
    t_req  in_data   = '0;
    logic  out_ready = 1'b0;
    logic  in_ready;
    logic  out_valid;
    t_rsp  out_data;

    logic [7:0] str_a [MAX_LEN];
    logic [7:0] str_b [MAX_LEN];
    int         len_a = 0;
    int         len_b = 0;
    bit         chars_lost = 1'b0;
    t_rsp       dist_due [$];

    int mismatches = 0;
    int send_calm  = 0;
    int recv_calm  = 0;
    int recv_hold  = 0;
    int quiet      = 0;

    edit_distance_engine i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    function automatic t_req make_req(input t_req_type op, input logic [7:0] ch);
        t_req r;
        r.req_type = op;
        r.char_in  = ch;
        return r;
    endfunction

    function automatic logic [DIST_W-1:0] levenshtein_dist();
        int row [MAX_LEN + 1];
        int diag;
        int up;
        int best;
        for (int i = 0; i <= len_a; i++) row[i] = i;
        for (int j = 1; j <= len_b; j++) begin
            diag   = row[0];
            row[0] = j;
            for (int i = 1; i <= len_a; i++) begin
                up = row[i];
                if (str_a[i-1] == str_b[j-1]) begin
                    row[i] = diag;
                end else begin
                    best = up;
                    if (row[i-1] < best) best = row[i-1];
                    if (diag < best) best = diag;
                    row[i] = best + 1;
                end
                diag = up;
            end
        end
        return (row[len_a] > DIST_MAX) ? DIST_W'(DIST_MAX) : DIST_W'(row[len_a]);
    endfunction

    task automatic track_request(input t_req beat, input bit known, input t_rsp typed_rsp);
        t_rsp rsp;
        case (beat.req_type)
            REQ_APPEND_A: begin
                if (len_a < MAX_LEN) begin
                    str_a[len_a] = beat.char_in;
                    len_a++;
                end else begin
                    chars_lost = 1'b1;
                end
            end
            REQ_APPEND_B: begin
                if (len_b < MAX_LEN) begin
                    str_b[len_b] = beat.char_in;
                    len_b++;
                end else begin
                    chars_lost = 1'b1;
                end
            end
            REQ_COMPUTE: begin
                rsp.distance = levenshtein_dist();
                rsp.overflow = chars_lost;
                dist_due.push_back(known ? typed_rsp : rsp);
                len_a      = 0;
                len_b      = 0;
                chars_lost = 1'b0;
            end
            default: ;
        endcase
    endtask

    task automatic send_beat(input t_req beat, input bit known = 1'b0, input t_rsp typed_rsp = '0);
        int gap;
        if (send_calm > 0) begin
            gap = 0;
            send_calm--;
        end else begin
            gap = $urandom_range(0, 15);
            if ($urandom_range(0, 7) == 0) send_calm = $urandom_range(8, 40);
        end
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_valid <= 1'b1;
        in_data  <= beat;
        @(posedge i_clk);
        while (!in_ready) @(posedge i_clk);
        track_request(beat, known, typed_rsp);
    endtask

    task automatic wait_drained();
        if (dist_due.size() != 0) begin
            in_valid <= 1'b0;
            while (dist_due.size() != 0) @(posedge i_clk);
        end
    endtask

    task automatic note_mismatch(input string what, input int want, input int got);
        mismatches++;
        if (mismatches <= REPORT_MAX)
            $display("%0t: %s mismatch: expected %0d, got %0d", $realtime, what, want, got);
    endtask

    always @(posedge i_clk) begin : rsp_check
        t_rsp hope;
        int   hold;
        if (rst_n && out_valid && out_ready) begin
            if (dist_due.size() == 0) begin
                note_mismatch("unexpected beat distance", -1, int'(out_data.distance));
            end else begin
                hope = dist_due.pop_front();
                if (out_data.distance !== hope.distance)
                    note_mismatch("distance", int'(hope.distance), int'(out_data.distance));
                if (out_data.overflow !== hope.overflow)
                    note_mismatch("overflow", int'(hope.overflow), int'(out_data.overflow));
            end
            if (recv_calm > 0) begin
                hold = 0;
                recv_calm <= recv_calm - 1;
            end else begin
                hold = $urandom_range(0, 15);
                if ($urandom_range(0, 7) == 0) recv_calm <= $urandom_range(8, 30);
            end
            if (hold == 0) begin
                out_ready <= 1'b1;
            end else begin
                out_ready <= 1'b0;
                recv_hold <= hold;
            end
        end else if (!out_ready) begin
            if (recv_hold <= 1) out_ready <= 1'b1;
            else recv_hold <= recv_hold - 1;
        end
    end

    always @(posedge i_clk) begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
            quiet <= 0;
        end else if (quiet >= WATCHDOG) begin
            $display("edit_distance_engine_test NOT OK");
            $finish;
        end else begin
            quiet <= quiet + 1;
        end
    end

    initial begin
        int        sent;
        int        na;
        int        nb;
        int        base;
        bit        wide;
        t_req_type op;
        logic [7:0] ch;
        t_rsp      typed;

        sent = 0;
        repeat (3) @(posedge i_clk);
        rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (script[r]) begin
            typed.distance = script[r].want_dist;
            typed.overflow = script[r].ovf;
            for (int k = 0; k < script[r].reps; k++)
                send_beat(make_req(script[r].op, script[r].ch), script[r].known, typed);
        end
        wait_drained();

        while (sent < RANDOM_ITEMS) begin
            if ($urandom_range(0, 9) == 0) wait_drained();
            if ($urandom_range(0, 15) == 0) begin
                na = $urandom_range(MAX_LEN - 6, MAX_LEN + 4);
                nb = $urandom_range(MAX_LEN - 6, MAX_LEN + 4);
            end else begin
                na = $urandom_range(0, 10);
                nb = $urandom_range(0, 10);
            end
            base = $urandom_range(0, 255);
            wide = ($urandom_range(0, 3) == 0);
            while (na + nb > 0) begin
                if (na > 0 && (nb == 0 || $urandom_range(0, 1) == 1)) begin
                    op = REQ_APPEND_A;
                    na--;
                end else begin
                    op = REQ_APPEND_B;
                    nb--;
                end
                ch = wide ? 8'($urandom_range(0, 255)) : 8'(base + $urandom_range(0, 3));
                if ($urandom_range(0, 19) == 0)
                    send_beat(make_req(REQ_UNUSED, 8'($urandom_range(0, 255))));
                send_beat(make_req(op, ch));
                sent++;
            end
            // drop the compute now and then so the strings carry into the next run
            if ($urandom_range(0, 11) != 0) begin
                send_beat(make_req(REQ_COMPUTE, 8'($urandom_range(0, 255))));
                sent++;
            end
        end
        send_beat(make_req(REQ_COMPUTE, 8'h00));

        wait_drained();
        repeat (SETTLE) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("edit_distance_engine_test OK");
        end else begin
            $display("edit_distance_engine_test NOT OK");
        end
        $finish;
    end

endmodule
